// ----- rtl/core/kptb_pkg.sv -----
// Package for the keypad tuned burst wave generator: widths, codes, defaults and helpers.
`timescale 1ns / 1ps

package kptb_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int PRESCALE_BITS = 10;
    localparam int RATIO_BITS    = PRESCALE_BITS + 1;
    localparam int WIDE_BITS     = COUNT_BITS + 11;
    localparam int KEY_BITS      = 8;
    localparam int DIV_BITS      = 3;

    typedef logic [COUNT_BITS-1:0]    count_t;
    typedef logic [WIDE_BITS-1:0]     wide_t;
    typedef logic [RATIO_BITS-1:0]    ratio_t;
    typedef logic [PRESCALE_BITS-1:0] prescale_t;
    typedef logic [KEY_BITS-1:0]      key_t;

    typedef enum logic [DIV_BITS-1:0] {
        DIV_1024 = 3'd0,
        DIV_1    = 3'd1,
        DIV_8    = 3'd2,
        DIV_64   = 3'd3,
        DIV_256  = 3'd4
    } div_sel_t;

    typedef struct packed {
        logic cmd;
        key_t key_code;
    } item_t;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KEY  = 1'b1;

    localparam key_t KEY_0    = 8'h30;
    localparam key_t KEY_1    = 8'h31;
    localparam key_t KEY_2    = 8'h32;
    localparam key_t KEY_3    = 8'h33;
    localparam key_t KEY_4    = 8'h34;
    localparam key_t KEY_5    = 8'h35;
    localparam key_t KEY_6    = 8'h36;
    localparam key_t KEY_7    = 8'h37;
    localparam key_t KEY_8    = 8'h38;
    localparam key_t KEY_9    = 8'h39;
    localparam key_t KEY_A    = 8'h41;
    localparam key_t KEY_B    = 8'h42;
    localparam key_t KEY_C    = 8'h43;
    localparam key_t KEY_D    = 8'h44;
    localparam key_t KEY_STAR = 8'h2A;
    localparam key_t KEY_HASH = 8'h23;

    localparam longint unsigned COUNT_MAX_L = (64'd1 << COUNT_BITS) - 64'd1;

    function automatic count_t clamp_const(input longint unsigned v);
        return COUNT_BITS'((v > COUNT_MAX_L) ? COUNT_MAX_L : v);
    endfunction

    localparam count_t COUNT_MAX     = '1;
    localparam count_t COMPARE_RESET = clamp_const(64'd2048);
    localparam count_t ON_RESET      = clamp_const(64'd8000);
    localparam count_t OFF_RESET     = clamp_const(64'd10);
    localparam count_t COMPARE_FLOOR = clamp_const(64'd3);
    localparam count_t ZERO_FLOOR    = '0;

    localparam wide_t STEP_1    = WIDE_BITS'(1);
    localparam wide_t STEP_10   = WIDE_BITS'(10);
    localparam wide_t STEP_100  = WIDE_BITS'(100);
    localparam wide_t STEP_1000 = WIDE_BITS'(1000);

    function automatic ratio_t divide_ratio(input div_sel_t sel);
        ratio_t r;
        unique case (sel)
            DIV_1:   r = RATIO_BITS'(1);
            DIV_8:   r = RATIO_BITS'(8);
            DIV_64:  r = RATIO_BITS'(64);
            DIV_256: r = RATIO_BITS'(256);
            default: r = RATIO_BITS'(1024);
        endcase
        return r;
    endfunction

    function automatic div_sel_t next_divide(input div_sel_t sel);
        div_sel_t n;
        unique case (sel)
            DIV_1024: n = DIV_1;
            DIV_1:    n = DIV_8;
            DIV_8:    n = DIV_64;
            DIV_64:   n = DIV_256;
            default:  n = DIV_1024;
        endcase
        return n;
    endfunction

    function automatic count_t raise_sat(input count_t v, input wide_t d);
        wide_t s;
        s = WIDE_BITS'(v) + d;
        return (s > WIDE_BITS'(COUNT_MAX)) ? COUNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    function automatic count_t lower_floor(input count_t v, input wide_t d, input count_t fl);
        wide_t vw;
        wide_t diff;
        vw   = WIDE_BITS'(v);
        diff = vw - d;
        if (vw < d || diff < WIDE_BITS'(fl))
            return fl;
        return diff[COUNT_BITS-1:0];
    endfunction

endpackage

// ----- rtl/core/kptb_if.sv -----
// Handshake channels for key and tick items and for status items.
`timescale 1ns / 1ps

interface kptb_cmd_if;
    logic          valid;
    logic          ready;
    logic          cmd;
    kptb_pkg::key_t key_code;

    modport source (output valid, output cmd, output key_code, input ready);
    modport sink   (input valid, input cmd, input key_code, output ready);
endinterface

interface kptb_res_if;
    logic               valid;
    logic               ready;
    logic               osc_level;
    logic               gate_level;
    kptb_pkg::count_t   compare_now;
    logic [kptb_pkg::DIV_BITS-1:0] divide_select;
    kptb_pkg::count_t   on_span;
    kptb_pkg::count_t   off_span;

    modport source (output valid, output osc_level, output gate_level, output compare_now,
                    output divide_select, output on_span, output off_span, input ready);
    modport sink   (input valid, input osc_level, input gate_level, input compare_now,
                    input divide_select, input on_span, input off_span, output ready);
endinterface

// ----- rtl/core/kptb_in_stage.sv -----
// Input register stage holding one accepted item.
`timescale 1ns / 1ps

module kptb_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    kptb_cmd_if.sink        keys,
    output logic            item_valid,
    output kptb_pkg::item_t item,
    input  logic            item_ready
);

    logic            valid_reg;
    logic            valid_next;
    kptb_pkg::item_t item_reg;
    logic            take;

    assign keys.ready = !valid_reg || item_ready;
    assign take       = keys.valid && keys.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (item_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.cmd      <= keys.cmd;
            item_reg.key_code <= keys.key_code;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/core/kptb_engine.sv -----
// Generator state, single pass update per item and status register.
`timescale 1ns / 1ps

module kptb_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  kptb_pkg::item_t item,
    output logic            item_ready,
    kptb_res_if.source      status
);

    kptb_pkg::prescale_t prescale_reg, prescale_next;
    kptb_pkg::count_t    timer_reg, timer_next;
    kptb_pkg::count_t    compare_reg, compare_next;
    kptb_pkg::div_sel_t  div_reg, div_next;
    kptb_pkg::count_t    on_reg, on_next;
    kptb_pkg::count_t    off_reg, off_next;
    kptb_pkg::count_t    match_reg, match_next;
    logic                osc_reg, osc_next;
    logic                gate_reg, gate_next;
    logic                out_valid_reg, out_valid_next;

    logic                          fire;
    kptb_pkg::ratio_t              pre_inc;
    kptb_pkg::count_t              match_inc;
    logic [kptb_pkg::COUNT_BITS:0] burst_sum;
    logic                          past_off;
    logic                          past_burst;

    assign item_ready = !out_valid_reg || status.ready;
    assign fire       = item_valid && item_ready;

    assign pre_inc    = kptb_pkg::RATIO_BITS'(prescale_reg) + kptb_pkg::RATIO_BITS'(1);
    assign match_inc  = match_reg + kptb_pkg::COUNT_BITS'(1);
    assign burst_sum  = {1'b0, off_reg} + {1'b0, on_reg};
    assign past_off   = match_inc > off_reg;
    assign past_burst = {1'b0, match_inc} > burst_sum;

    always_comb
    begin
        prescale_next  = prescale_reg;
        timer_next     = timer_reg;
        compare_next   = compare_reg;
        div_next       = div_reg;
        on_next        = on_reg;
        off_next       = off_reg;
        match_next     = match_reg;
        osc_next       = osc_reg;
        gate_next      = gate_reg;
        out_valid_next = out_valid_reg;

        if (fire)
        begin
            out_valid_next = 1'b1;
            if (item.cmd == kptb_pkg::CMD_KEY)
            begin
                unique case (item.key_code)
                    kptb_pkg::KEY_1:
                        compare_next = kptb_pkg::raise_sat(compare_reg, kptb_pkg::STEP_1);
                    kptb_pkg::KEY_2:
                        compare_next = kptb_pkg::raise_sat(compare_reg, kptb_pkg::STEP_10);
                    kptb_pkg::KEY_3:
                        compare_next = kptb_pkg::raise_sat(compare_reg, kptb_pkg::STEP_100);
                    kptb_pkg::KEY_A:
                        compare_next = kptb_pkg::raise_sat(compare_reg, kptb_pkg::STEP_1000);
                    kptb_pkg::KEY_4:
                        compare_next = kptb_pkg::lower_floor(compare_reg, kptb_pkg::STEP_1,
                                                             kptb_pkg::COMPARE_FLOOR);
                    kptb_pkg::KEY_5:
                        compare_next = kptb_pkg::lower_floor(compare_reg, kptb_pkg::STEP_10,
                                                             kptb_pkg::COMPARE_FLOOR);
                    kptb_pkg::KEY_6:
                        compare_next = kptb_pkg::lower_floor(compare_reg, kptb_pkg::STEP_100,
                                                             kptb_pkg::COMPARE_FLOOR);
                    kptb_pkg::KEY_B:
                        compare_next = kptb_pkg::lower_floor(compare_reg, kptb_pkg::STEP_1000,
                                                             kptb_pkg::COMPARE_FLOOR);
                    kptb_pkg::KEY_7:
                        on_next = kptb_pkg::raise_sat(on_reg, kptb_pkg::STEP_1);
                    kptb_pkg::KEY_8:
                        on_next = kptb_pkg::raise_sat(on_reg, kptb_pkg::STEP_10);
                    kptb_pkg::KEY_STAR:
                        on_next = kptb_pkg::lower_floor(on_reg, kptb_pkg::STEP_1,
                                                        kptb_pkg::ZERO_FLOOR);
                    kptb_pkg::KEY_0:
                        on_next = kptb_pkg::lower_floor(on_reg, kptb_pkg::STEP_10,
                                                        kptb_pkg::ZERO_FLOOR);
                    kptb_pkg::KEY_9:
                        off_next = kptb_pkg::raise_sat(off_reg, kptb_pkg::STEP_1);
                    kptb_pkg::KEY_HASH:
                        off_next = kptb_pkg::lower_floor(off_reg, kptb_pkg::STEP_1,
                                                         kptb_pkg::ZERO_FLOOR);
                    kptb_pkg::KEY_C:
                    begin
                        div_next      = kptb_pkg::next_divide(div_reg);
                        prescale_next = '0;
                    end
                    kptb_pkg::KEY_D:
                    begin
                        compare_next  = kptb_pkg::COMPARE_RESET;
                        div_next      = kptb_pkg::DIV_1024;
                        on_next       = kptb_pkg::ON_RESET;
                        off_next      = kptb_pkg::OFF_RESET;
                        prescale_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (pre_inc >= kptb_pkg::divide_ratio(div_reg))
            begin
                prescale_next = '0;
                if (timer_reg == compare_reg)
                begin
                    timer_next = '0;
                    osc_next   = !osc_reg;
                    match_next = match_inc;
                    if (past_off)
                        gate_next = 1'b0;
                    if (past_burst)
                    begin
                        gate_next  = 1'b1;
                        match_next = '0;
                    end
                end
                else
                begin
                    timer_next = timer_reg + kptb_pkg::COUNT_BITS'(1);
                end
            end
            else
            begin
                prescale_next = pre_inc[kptb_pkg::PRESCALE_BITS-1:0];
            end
        end
        else if (status.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg  <= '0;
            timer_reg     <= '0;
            compare_reg   <= kptb_pkg::COMPARE_RESET;
            div_reg       <= kptb_pkg::DIV_1024;
            on_reg        <= kptb_pkg::ON_RESET;
            off_reg       <= kptb_pkg::OFF_RESET;
            match_reg     <= '0;
            osc_reg       <= 1'b1;
            gate_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prescale_reg  <= prescale_next;
            timer_reg     <= timer_next;
            compare_reg   <= compare_next;
            div_reg       <= div_next;
            on_reg        <= on_next;
            off_reg       <= off_next;
            match_reg     <= match_next;
            osc_reg       <= osc_next;
            gate_reg      <= gate_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.valid         = out_valid_reg;
    assign status.osc_level     = osc_reg;
    assign status.gate_level    = gate_reg;
    assign status.compare_now   = compare_reg;
    assign status.divide_select = div_reg;
    assign status.on_span       = on_reg;
    assign status.off_span      = off_reg;

endmodule

// ----- rtl/core/keypad_tuned_burst_wave_generator.sv -----
// Top level of the keypad tuned burst wave generator.
//
//  channel  direction  payload
//  keys     sink       cmd, key_code
//  status   source     osc_level, gate_level, compare_now, divide_select, on_span, off_span
//
//  One item per cycle sustained while status is ready; a taken item passes the input
//  register, then the state and status registers updated in one pass.
//  The status item is the generator state right after its item is applied.
//  A stalled status item holds; keys stays ready while the input register can move on.
//  Reset loads compare 2048, divide by 1024, on 8000, off 10, oscillator and gate high.
`timescale 1ns / 1ps

module keypad_tuned_burst_wave_generator (
    input  logic       clk,
    input  logic       rst_n,
    kptb_cmd_if.sink   keys,
    kptb_res_if.source status
);

    logic            item_valid;
    logic            item_ready;
    kptb_pkg::item_t item;

    kptb_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .keys       (keys),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready)
    );

    kptb_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .status     (status)
    );

endmodule

// ----- rtl/core/kptb_checker.sv -----
// Port level checks for the generator and their binding to the top level.
`timescale 1ns / 1ps

module kptb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input kptb_pkg::count_t              compare_now,
    input logic [kptb_pkg::DIV_BITS-1:0] divide_select,
    input logic                          in_valid,
    input logic                          in_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("status item dropped while stalled");

    a_compare_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> compare_now >= kptb_pkg::COMPARE_FLOOR)
        else $error("compare value below its floor");

    a_divide_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> divide_select <= kptb_pkg::DIV_BITS'(kptb_pkg::DIV_256))
        else $error("divide select out of range");

    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("accepted item did not produce a status item");

endmodule

bind keypad_tuned_burst_wave_generator kptb_checker u_kptb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (status.valid),
    .out_ready     (status.ready),
    .compare_now   (status.compare_now),
    .divide_select (status.divide_select),
    .in_valid      (keys.valid),
    .in_ready      (keys.ready)
);

// ----- tb/kptb_status_checker.sv -----
`timescale 1ns / 1ps
// Status checker for the burst wave generator: tracks generator state per item and compares.

module kptb_status_checker
    import kptb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    kptb_cmd_if  keys,
    kptb_res_if  status,
    output int   fail_count,
    output int   pending,
    output int   results_seen,
    output int   matches_seen,
    output int   restarts_seen
);

    typedef struct packed {
        logic                osc;
        logic                gate;
        count_t              compare;
        logic [DIV_BITS-1:0] divide;
        count_t              on_span;
        count_t              off_span;
    } gen_status_t;

    prescale_t   pre_q;
    count_t      timer_q;
    count_t      compare_q;
    count_t      on_q;
    count_t      off_q;
    count_t      burst_q;
    div_sel_t    div_q;
    logic        osc_q;
    logic        gate_q;
    gen_status_t status_due [$];

    function automatic count_t bump_up(input count_t v, input int unsigned step);
        longint unsigned s;
        s = 64'(v) + 64'(step);
        return (s > 64'(COUNT_MAX)) ? COUNT_MAX : count_t'(s);
    endfunction

    function automatic count_t bump_down(input count_t v, input int unsigned step,
                                         input count_t fl);
        longint unsigned w;
        w = 64'(v);
        if (w < 64'(step) || w - 64'(step) < 64'(fl))
            return fl;
        return count_t'(w - 64'(step));
    endfunction

    function automatic int unsigned ratio_of(input div_sel_t d);
        case (d)
            DIV_1:   return 1;
            DIV_8:   return 8;
            DIV_64:  return 64;
            DIV_256: return 256;
            default: return 1024;
        endcase
    endfunction

    function automatic gen_status_t snapshot();
        gen_status_t s;
        s.osc      = osc_q;
        s.gate     = gate_q;
        s.compare  = compare_q;
        s.divide   = div_q;
        s.on_span  = on_q;
        s.off_span = off_q;
        return s;
    endfunction

    task automatic load_defaults();
        compare_q = COMPARE_RESET;
        div_q     = DIV_1024;
        on_q      = ON_RESET;
        off_q     = OFF_RESET;
        pre_q     = '0;
    endtask

    task automatic advance_tick();
        if (32'(pre_q) + 1 >= ratio_of(div_q))
        begin
            pre_q = '0;
            if (timer_q == compare_q)
            begin
                timer_q = '0;
                osc_q   = ~osc_q;
                burst_q = burst_q + 1'b1;
                matches_seen++;
                if (burst_q > off_q)
                    gate_q = 1'b0;
                if (17'(burst_q) > 17'(off_q) + 17'(on_q))
                begin
                    gate_q  = 1'b1;
                    burst_q = '0;
                    restarts_seen++;
                end
            end
            else
                timer_q = timer_q + 1'b1;
        end
        else
            pre_q = pre_q + 1'b1;
    endtask

    task automatic press_key(input key_t k);
        case (k)
            KEY_1:    compare_q = bump_up(compare_q, 1);
            KEY_2:    compare_q = bump_up(compare_q, 10);
            KEY_3:    compare_q = bump_up(compare_q, 100);
            KEY_A:    compare_q = bump_up(compare_q, 1000);
            KEY_4:    compare_q = bump_down(compare_q, 1, COMPARE_FLOOR);
            KEY_5:    compare_q = bump_down(compare_q, 10, COMPARE_FLOOR);
            KEY_6:    compare_q = bump_down(compare_q, 100, COMPARE_FLOOR);
            KEY_B:    compare_q = bump_down(compare_q, 1000, COMPARE_FLOOR);
            KEY_7:    on_q = bump_up(on_q, 1);
            KEY_8:    on_q = bump_up(on_q, 10);
            KEY_STAR: on_q = bump_down(on_q, 1, ZERO_FLOOR);
            KEY_0:    on_q = bump_down(on_q, 10, ZERO_FLOOR);
            KEY_9:    off_q = bump_up(off_q, 1);
            KEY_HASH: off_q = bump_down(off_q, 1, ZERO_FLOOR);
            KEY_C:
            begin
                case (div_q)
                    DIV_1024: div_q = DIV_1;
                    DIV_1:    div_q = DIV_8;
                    DIV_8:    div_q = DIV_64;
                    DIV_64:   div_q = DIV_256;
                    default:  div_q = DIV_1024;
                endcase
                pre_q = '0;
            end
            KEY_D:    load_defaults();
            default:  ;
        endcase
    endtask

    task automatic report(input string field, input longint unsigned want,
                          input longint unsigned seen);
        fail_count++;
        $display("%0t: status item %0d: %s expected %0h got %0h",
                 $realtime, results_seen, field, want, seen);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        gen_status_t want;
        gen_status_t seen;
        if (!rst_n)
        begin
            load_defaults();
            timer_q = '0;
            burst_q = '0;
            osc_q   = 1'b1;
            gate_q  = 1'b1;
            status_due.delete();
        end
        else
        begin
            if (status.valid && status.ready)
            begin
                seen.osc      = status.osc_level;
                seen.gate     = status.gate_level;
                seen.compare  = status.compare_now;
                seen.divide   = status.divide_select;
                seen.on_span  = status.on_span;
                seen.off_span = status.off_span;
                if (status_due.size() == 0)
                    report("unexpected item", 0, 64'(seen));
                else
                begin
                    want = status_due.pop_front();
                    if (seen.osc !== want.osc)
                        report("osc_level", want.osc, seen.osc);
                    if (seen.gate !== want.gate)
                        report("gate_level", want.gate, seen.gate);
                    if (seen.compare !== want.compare)
                        report("compare_now", want.compare, seen.compare);
                    if (seen.divide !== want.divide)
                        report("divide_select", want.divide, seen.divide);
                    if (seen.on_span !== want.on_span)
                        report("on_span", want.on_span, seen.on_span);
                    if (seen.off_span !== want.off_span)
                        report("off_span", want.off_span, seen.off_span);
                end
                results_seen++;
            end
            if (keys.valid && keys.ready)
            begin
                if (keys.cmd == CMD_KEY)
                    press_key(keys.key_code);
                else
                    advance_tick();
                status_due.push_back(snapshot());
            end
        end
        pending = status_due.size();
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the burst wave generator: clock, reset, key and tick stimulus, verdict.

module tb;
    import kptb_pkg::*;

    localparam key_t KEY_NONE = 8'h45;

    logic clk;
    logic rst_n;
    bit   steady;
    bit   hold_req;
    int   n_ticks;
    int   n_keys;
    int   fail_count;
    int   pending;
    int   results_seen;
    int   matches_seen;
    int   restarts_seen;

    key_t tune_keys [15] = '{KEY_0, KEY_1, KEY_2, KEY_3, KEY_4, KEY_5, KEY_6, KEY_7,
                             KEY_8, KEY_9, KEY_A, KEY_B, KEY_C, KEY_STAR, KEY_HASH};

    kptb_cmd_if keys ();
    kptb_res_if status ();

    keypad_tuned_burst_wave_generator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .keys   (keys),
        .status (status)
    );

    kptb_status_checker status_watch (
        .clk           (clk),
        .rst_n         (rst_n),
        .keys          (keys),
        .status        (status),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .matches_seen  (matches_seen),
        .restarts_seen (restarts_seen)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push(input logic c, input key_t k);
        int g;
        g = steady ? 0 : idle_span();
        if (g > 0)
        begin
            keys.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        keys.valid    <= 1'b1;
        keys.cmd      <= c;
        keys.key_code <= k;
        @(posedge clk);
        while (!keys.ready)
            @(posedge clk);
        if (c == CMD_KEY)
            n_keys++;
        else
            n_ticks++;
        @(negedge clk);
    endtask

    task automatic ticks(input int n);
        repeat (n) push(CMD_TICK, key_t'($urandom));
    endtask

    task automatic press(input key_t k, input int n);
        repeat (n) push(CMD_KEY, k);
    endtask

    initial
    begin
        int hold_left;
        bit held;
        hold_left    = 0;
        held         = 1'b0;
        status.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                held      = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                status.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                status.ready <= 1'b1;
                if (!steady)
                    hold_left = idle_span();
            end
        end
    end

    initial
    begin
        int sel;
        int climbs;
        int i;
        rst_n         = 1'b0;
        keys.valid    = 1'b0;
        keys.cmd      = CMD_TICK;
        keys.key_code = '0;
        climbs        = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push(CMD_TICK, '0);
        push(CMD_TICK, '1);
        push(CMD_KEY, '0);
        push(CMD_KEY, '1);
        push(CMD_KEY, KEY_NONE);
        press(KEY_1, 1);
        press(KEY_2, 1);
        press(KEY_3, 1);
        press(KEY_A, 1);
        press(KEY_4, 1);
        press(KEY_5, 1);
        press(KEY_6, 1);
        press(KEY_B, 1);
        press(KEY_7, 1);
        press(KEY_8, 1);
        press(KEY_STAR, 1);
        press(KEY_0, 1);
        press(KEY_9, 1);
        press(KEY_HASH, 1);
        press(KEY_C, 5);
        press(KEY_D, 1);

        // run the fastest divide against the lowest compare
        press(KEY_C, 1);
        press(KEY_B, 2);
        press(KEY_6, 1);
        steady = 1'b1;
        ticks(60);
        steady = 1'b0;

        // step the counts down, then raise off, while the status side holds off
        hold_req = 1'b1;
        press(KEY_D, 1);
        press(KEY_C, 1);
        press(KEY_0, 40);
        press(KEY_STAR, 3);
        press(KEY_HASH, 12);
        press(KEY_9, 2);

        while (n_ticks + n_keys < 850)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 50)
                ticks($urandom_range(10, 120));
            else if (sel < 75)
            begin
                repeat ($urandom_range(3, 12))
                begin
                    if ($urandom_range(0, 9) == 0)
                        push(CMD_KEY, key_t'($urandom));
                    else
                        push(CMD_KEY, tune_keys[$urandom_range(0, 14)]);
                end
            end
            else if (sel < 85)
            begin
                press(KEY_B, $urandom_range(1, 3));
                for (i = 0; i < $urandom_range(1, 6); i++)
                    press(tune_keys[$urandom_range(4, 6)], 1);
            end
            else if (sel < 90 && climbs < 1)
            begin
                climbs++;
                press(KEY_A, 66);
                press(KEY_B, 66);
            end
            else if (sel < 95)
                press(KEY_C, 1);
            else
            begin
                repeat ($urandom_range(2, 6))
                begin
                    case ($urandom_range(0, 3))
                        0:       press(KEY_9, 1);
                        1:       press(KEY_HASH, 1);
                        2:       press(KEY_7, 1);
                        default: press(KEY_STAR, 1);
                    endcase
                end
            end
        end
        keys.valid <= 1'b0;

        for (i = 0; i < 20000 && pending != 0; i++)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Run: %0d ticks and %0d key presses, %0d status items checked",
                 n_ticks, n_keys, results_seen);
        $display("Covered %0d compare matches, %0d burst restarts and the count limits",
                 matches_seen, restarts_seen);
        if (pending != 0)
            $display("%0d status items never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
